// ===== hdl/fhi_pkg.sv =====
// Shared types and constants of the Farrow/Horner interpolator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fhi_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int DELAY_W  = 16;
   localparam int SHIFT_W  = 5;

   // Product of a sample and the delay, and the Horner accumulator.
   // The accumulator holds a sample shifted up by the largest shift plus the
   // product and the rounding bias without wrapping.
   localparam int PROD_W = SAMPLE_W + DELAY_W;
   localparam int ACC_W  = SAMPLE_W + (1 << SHIFT_W);

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(15);

   // Saturation limits
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Input item
   typedef struct packed {
      logic signed [DELAY_W-1:0]  delay;
      logic signed [SAMPLE_W-1:0] y3_re;
      logic signed [SAMPLE_W-1:0] y3_im;
      logic signed [SAMPLE_W-1:0] y2_re;
      logic signed [SAMPLE_W-1:0] y2_im;
      logic signed [SAMPLE_W-1:0] y1_re;
      logic signed [SAMPLE_W-1:0] y1_im;
      logic signed [SAMPLE_W-1:0] y0_re;
      logic signed [SAMPLE_W-1:0] y0_im;
   } fhi_req_type;

   // Result item
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_re;
      logic signed [SAMPLE_W-1:0] out_im;
   } fhi_rsp_type;

   // One complex sample
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
   } fhi_cplx_type;

   // Item in flight between Horner steps: the running value, the delay and
   // the branch outputs still to be folded in (ys[0] is used next).
   typedef struct packed {
      logic signed [DELAY_W-1:0] delay;
      fhi_cplx_type              prev;
      fhi_cplx_type [2:0]        ys;
   } fhi_work_type;

endpackage

`default_nettype wire

// ===== hdl/fhi_round_sat.sv =====
// Round half away from zero, arithmetic right shift and saturation of one
// accumulator component. Combinational; depends on fhi_pkg.
`default_nettype none

module fhi_round_sat
   import fhi_pkg::*;
(
   input  logic signed [ACC_W-1:0]    acc,
   input  logic        [SHIFT_W-1:0]  shift,
   output logic signed [SAMPLE_W-1:0] result
);

   logic        [SHIFT_W-1:0]      shift_m1;
   logic signed [ACC_W-1:0]        half;
   logic signed [ACC_W-1:0]        bias;
   logic signed [ACC_W-1:0]        biased;
   logic signed [ACC_W-1:0]        shifted;
   logic        [ACC_W-SAMPLE_W:0] top_bits;
   logic                           fits;

   // Negative values take half minus one, so a floor shift rounds away
   // from zero on ties. A zero shift only saturates.
   always_comb begin
      shift_m1 = shift - SHIFT_W'(1);
      half     = ACC_W'(1) << shift_m1;
      if (shift == '0) begin
         bias = '0;
      end else begin
         bias = half - ACC_W'(acc[ACC_W-1]);
      end
      biased  = acc + bias;
      shifted = biased >>> shift;
   end

   // Saturate to the sample width
   always_comb begin
      top_bits = shifted[ACC_W-1:SAMPLE_W-1];
      fits     = (&top_bits) | ~(|top_bits);
      if (fits) begin
         result = shifted[SAMPLE_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         result = SAT_MIN;
      end else begin
         result = SAT_MAX;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/fhi_horner_stage.sv =====
// One Horner step, new = rnd(y * 2^S + prev * delay), on both parts of a
// complex sample, in three register stages: multiply, add, round/saturate.
// Depends on fhi_pkg and fhi_round_sat.
`default_nettype none

module fhi_horner_stage
   import fhi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [SHIFT_W-1:0] shift,
   input  logic               in_valid,
   output logic               in_stall,
   input  fhi_work_type       in_work,
   output logic               out_valid,
   input  logic               out_stall,
   output fhi_work_type       out_work
);

   // Multiply stage
   logic                     mul_valid_ff;
   fhi_work_type             mul_work_ff;
   logic signed [PROD_W-1:0] prod_re_ff, prod_re_in;
   logic signed [PROD_W-1:0] prod_im_ff, prod_im_in;
   logic signed [ACC_W-1:0]  ysh_re_ff, ysh_re_in;
   logic signed [ACC_W-1:0]  ysh_im_ff, ysh_im_in;

   // Add stage
   logic                     sum_valid_ff;
   fhi_work_type             sum_work_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]  acc_im_ff, acc_im_in;

   // Round stage (drives the outputs)
   logic                     rnd_valid_ff;
   fhi_work_type             rnd_work_ff, rnd_work_in;
   logic signed [SAMPLE_W-1:0] rnd_re, rnd_im;

   logic mul_adv, sum_adv, rnd_adv;

   // Each stage moves when it is empty or the one after it moves
   assign rnd_adv  = ~rnd_valid_ff | ~out_stall;
   assign sum_adv  = ~sum_valid_ff | rnd_adv;
   assign mul_adv  = ~mul_valid_ff | sum_adv;
   assign in_stall = ~mul_adv;

   // Products and shifted branch value
   always_comb begin
      prod_re_in = PROD_W'(in_work.prev.re) * PROD_W'(in_work.delay);
      prod_im_in = PROD_W'(in_work.prev.im) * PROD_W'(in_work.delay);
      ysh_re_in  = ACC_W'(in_work.ys[0].re) <<< shift;
      ysh_im_in  = ACC_W'(in_work.ys[0].im) <<< shift;
   end

   // Accumulator sums
   always_comb begin
      acc_re_in = ysh_re_ff + ACC_W'(prod_re_ff);
      acc_im_in = ysh_im_ff + ACC_W'(prod_im_ff);
   end

   fhi_round_sat u_rs_re (
      .acc    (acc_re_ff),
      .shift  (shift),
      .result (rnd_re)
   );

   fhi_round_sat u_rs_im (
      .acc    (acc_im_ff),
      .shift  (shift),
      .result (rnd_im)
   );

   // New running value; the branch list moves down by one
   always_comb begin
      rnd_work_in         = sum_work_ff;
      rnd_work_in.prev.re = rnd_re;
      rnd_work_in.prev.im = rnd_im;
      rnd_work_in.ys[0]   = sum_work_ff.ys[1];
      rnd_work_in.ys[1]   = sum_work_ff.ys[2];
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         rnd_valid_ff <= 1'b0;
      end else begin
         if (mul_adv) begin
            mul_valid_ff <= in_valid;
         end
         if (sum_adv) begin
            sum_valid_ff <= mul_valid_ff;
         end
         if (rnd_adv) begin
            rnd_valid_ff <= sum_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (mul_adv && in_valid) begin
         mul_work_ff <= in_work;
         prod_re_ff  <= prod_re_in;
         prod_im_ff  <= prod_im_in;
         ysh_re_ff   <= ysh_re_in;
         ysh_im_ff   <= ysh_im_in;
      end
      if (sum_adv && mul_valid_ff) begin
         sum_work_ff <= mul_work_ff;
         acc_re_ff   <= acc_re_in;
         acc_im_ff   <= acc_im_in;
      end
      if (rnd_adv && sum_valid_ff) begin
         rnd_work_ff <= rnd_work_in;
      end
   end

   assign out_valid = rnd_valid_ff;
   assign out_work  = rnd_work_ff;

endmodule

`default_nettype wire

// ===== hdl/farrow_horner_interpolator_core.sv =====
// Top level of the cubic Farrow interpolator (Horner form).
// Depends on fhi_pkg and fhi_horner_stage.
//
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid/req_stall  | fhi_req_type (delay, y3..y0)
//  rsp     | out       | rsp_valid/rsp_stall  | fhi_rsp_type (out_re, out_im)
//  csr     | in        | csr_wr_en            | csr_wr_data (shift_amount)
//
// One sample per clock while rsp is not stalled; three Horner steps of three
// register stages each (multiply, add, round/saturate).
// Synchronous active-high reset empties the pipeline and sets the shift to 15.
// Each stage holds while its successor is full and stalled; bubbles close
// up, so transfers on req continue while a result waits on rsp.
`default_nettype none

module farrow_horner_interpolator_core
   import fhi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fhi_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fhi_rsp_type        rsp_data,
   input  logic               csr_wr_en,
   input  logic [SHIFT_W-1:0] csr_wr_data
);

   logic [SHIFT_W-1:0] shift_ff;
   fhi_work_type       work0;
   fhi_work_type       work1, work2, work3;
   logic               valid1, valid2;
   logic               stall1, stall2;

   // Shift register
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else if (csr_wr_en) begin
         shift_ff <= csr_wr_data;
      end
   end

   // Start of the recursion: running value y3, then y2, y1, y0
   always_comb begin
      work0.delay    = req_data.delay;
      work0.prev.re  = req_data.y3_re;
      work0.prev.im  = req_data.y3_im;
      work0.ys[0].re = req_data.y2_re;
      work0.ys[0].im = req_data.y2_im;
      work0.ys[1].re = req_data.y1_re;
      work0.ys[1].im = req_data.y1_im;
      work0.ys[2].re = req_data.y0_re;
      work0.ys[2].im = req_data.y0_im;
   end

   fhi_horner_stage u_step2 (
      .clock     (clock),
      .reset     (reset),
      .shift     (shift_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_work   (work0),
      .out_valid (valid1),
      .out_stall (stall1),
      .out_work  (work1)
   );

   fhi_horner_stage u_step1 (
      .clock     (clock),
      .reset     (reset),
      .shift     (shift_ff),
      .in_valid  (valid1),
      .in_stall  (stall1),
      .in_work   (work1),
      .out_valid (valid2),
      .out_stall (stall2),
      .out_work  (work2)
   );

   fhi_horner_stage u_step0 (
      .clock     (clock),
      .reset     (reset),
      .shift     (shift_ff),
      .in_valid  (valid2),
      .in_stall  (stall2),
      .in_work   (work2),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_work  (work3)
   );

   assign rsp_data.out_re = work3.prev.re;
   assign rsp_data.out_im = work3.prev.im;

endmodule

`default_nettype wire

// ===== hdl/fhi_checker.sv =====
// Port-level checks of the interpolator core and the bind that attaches them.
// Depends on fhi_pkg and farrow_horner_interpolator_core.
`default_nettype none

module fhi_checker
   import fhi_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input fhi_rsp_type        rsp_data
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input back-pressure only comes from a full pipeline stalled at the output
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // A stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   // and keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind farrow_horner_interpolator_core fhi_checker u_fhi_checker (.*);

`default_nettype wire

// ===== bench/farrow_horner_interpolator_core_tb.sv =====
// Self-checking bench for the cubic Farrow interpolator core (Horner form).
// Needs fhi_pkg and the farrow_horner_interpolator_core RTL; nothing else.
`timescale 1ns / 1ps

module farrow_horner_interpolator_core_tb;
   import fhi_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 2000;  // cycles without any transfer
   localparam int unsigned DRAIN_CYCLES = 20;    // pipeline is 9 deep
   localparam int unsigned PHASE_ITEMS  = 130;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [DELAY_W-1:0]  delay_type;

   // One directed vector; 'known' marks a hand-written expected sample
   typedef struct {
      logic [SHIFT_W-1:0] shift;
      fhi_req_type        sample;
      bit                 known;
      fhi_rsp_type        want;
   } vector_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   fhi_req_type        req_data    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   fhi_rsp_type        rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [SHIFT_W-1:0] csr_wr_data = '0;

   int unsigned sender_pct   = 0;
   int unsigned receiver_pct = 0;
   int unsigned active_shift = SHIFT_RESET;
   int unsigned quiet_cycles = 0;
   int          failures     = 0;

   fhi_rsp_type pending_outputs[$];
   vector_type  directed_rows[$];

   farrow_horner_interpolator_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Shift down by s, round half away from zero, clamp to the sample range
   function automatic sample_type round_saturate(longint acc, int unsigned s);
      longint mag;
      longint r;
      mag = (acc < 0) ? -acc : acc;
      if (s != 0)
         mag = (mag + (longint'(1) << (s - 1))) >>> s;
      r = (acc < 0) ? -mag : mag;
      if (r > longint'(SAT_MAX))
         return SAT_MAX;
      if (r < longint'(SAT_MIN))
         return SAT_MIN;
      return SAMPLE_W'(r);
   endfunction

   // One Horner step: rnd(y * 2^s + prev * d); exact in 64 bits for s <= 31
   function automatic sample_type horner_step(sample_type y, sample_type prev,
                                              delay_type d, int unsigned s);
      longint acc;
      acc = (longint'(y) <<< s) + longint'(prev) * longint'(d);
      return round_saturate(acc, s);
   endfunction

   function automatic fhi_rsp_type interpolate(fhi_req_type x, int unsigned s);
      fhi_rsp_type r;
      r.out_re = horner_step(x.y0_re,
                    horner_step(x.y1_re,
                       horner_step(x.y2_re, x.y3_re, x.delay, s), x.delay, s),
                    x.delay, s);
      r.out_im = horner_step(x.y0_im,
                    horner_step(x.y1_im,
                       horner_step(x.y2_im, x.y3_im, x.delay, s), x.delay, s),
                    x.delay, s);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic fhi_req_type make_sample(delay_type d,
                                               sample_type y3r, sample_type y3i,
                                               sample_type y2r, sample_type y2i,
                                               sample_type y1r, sample_type y1i,
                                               sample_type y0r, sample_type y0i);
      fhi_req_type x;
      x.delay = d;
      x.y3_re = y3r;
      x.y3_im = y3i;
      x.y2_re = y2r;
      x.y2_im = y2i;
      x.y1_re = y1r;
      x.y1_im = y1i;
      x.y0_re = y0r;
      x.y0_im = y0i;
      return x;
   endfunction

   function automatic fhi_rsp_type make_output(sample_type re, sample_type im);
      fhi_rsp_type r;
      r.out_re = re;
      r.out_im = im;
      return r;
   endfunction

   function automatic void add_row(logic [SHIFT_W-1:0] shift, fhi_req_type sample,
                                   bit known, fhi_rsp_type want);
      vector_type v;
      v.shift  = shift;
      v.sample = sample;
      v.known  = known;
      v.want   = want;
      directed_rows.push_back(v);
   endfunction

   function automatic sample_type pick_extreme();
      case ($urandom_range(0, 4))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return 1;
         3: return -1;
         default: return 0;
      endcase
   endfunction

   // Branch value: full range, small magnitude or an extreme
   function automatic sample_type rand_branch();
      case ($urandom_range(0, 4))
         0, 1: return SAMPLE_W'($urandom);
         2: return SAMPLE_W'(int'($urandom_range(0, 600)) - 300);
         default: return pick_extreme();
      endcase
   endfunction

   // Delay: mostly within +/-1.0 at the current shift so that results
   // do not all saturate
   function automatic delay_type rand_delay(int unsigned s);
      int lim;
      lim = 1 << ((s > 15) ? 15 : s);
      case ($urandom_range(0, 3))
         0: return DELAY_W'($urandom);
         1, 2: return DELAY_W'(int'($urandom_range(0, 2 * lim)) - lim);
         default: return pick_extreme();
      endcase
   endfunction

   function automatic fhi_req_type random_sample(int unsigned s);
      return make_sample(rand_delay(s), rand_branch(), rand_branch(),
                         rand_branch(), rand_branch(), rand_branch(),
                         rand_branch(), rand_branch(), rand_branch());
   endfunction

   // ---------------------------------------------------------------------
   // Driving tasks
   // ---------------------------------------------------------------------

   // Offer one sample; the expected output is queued on the transfer
   task automatic send_sample(fhi_req_type x, bit known, fhi_rsp_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= x;
      do
         @(posedge clock);
      while (req_stall);
      pending_outputs.push_back(known ? want : interpolate(x, active_shift));
   endtask

   // Hold off the sender until every queued output has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_shift(int unsigned s);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= SHIFT_W'(s);
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      active_shift  = s;
   endtask

   // ---------------------------------------------------------------------
   // Receiver back-pressure
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_pct);
   end

   // ---------------------------------------------------------------------
   // Output checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      fhi_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            $error("unexpected output transfer: out_re %0d out_im %0d",
                   rsp_data.out_re, rsp_data.out_im);
            failures++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_data.out_re !== want.out_re) begin
               $error("out_re: expected %0d, got %0d", want.out_re, rsp_data.out_re);
               failures++;
            end
            if (rsp_data.out_im !== want.out_im) begin
               $error("out_im: expected %0d, got %0d", want.out_im, rsp_data.out_im);
               failures++;
            end
         end
      end
   end

   // Watchdog: too long without a transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[farrow_horner_interpolator_core] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int unsigned shift_plan[8];
      int unsigned mode;

      // Directed vectors, grouped by shift; shift 15 is the reset value
      add_row(15, make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_output(0, 0));
      // zero delay passes y0 straight through
      add_row(15, make_sample(0, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                              1234, -1234, 16'h7fff, 16'h8000),
              1, make_output(16'sh7fff, 16'sh8000));
      // delay -1.0 with empty higher branches still gives y0
      add_row(15, make_sample(16'h8000, 0, 0, 0, 0, 0, 0, -5, 5), 1, make_output(-5, 5));
      add_row(15, make_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                              16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 0, '0);
      add_row(15, make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h8000, 16'h8000), 0, '0);
      add_row(15, make_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                              16'h7fff, 16'h8000, 16'h7fff, 16'h8000), 0, '0);
      // exact halves: rounding goes away from zero on both signs
      add_row(15, make_sample(16'h4000, 1, -1, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(15, make_sample(1, 3, -3, 0, 0, 7, -7, 0, 0), 0, '0);
      // shift of zero: no rounding, saturation only
      add_row(0, make_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                             16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff),
              1, make_output(SAT_MAX, SAT_MAX));
      add_row(0, make_sample(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                             16'h8000, 16'h8000, 16'h8000, 16'h8000),
              1, make_output(SAT_MIN, SAT_MIN));
      add_row(0, make_sample(1, 1, 2, 3, 4, 5, 6, 7, 8), 0, '0);
      add_row(0, make_sample(-1, 1, 2, 3, 4, 5, 6, 7, 8), 0, '0);
      add_row(0, make_sample(0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                             16'h7fff, 16'h7fff, 100, -100), 1, make_output(100, -100));
      // shift of 31, the largest value of the shift field
      add_row(31, make_sample(16'h8000, 16'h8000, 16'h7fff, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(31, make_sample(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h7fff, 16'h8000),
              1, make_output(16'sh7fff, 16'sh8000));
      add_row(31, make_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                              16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 0, '0);
      add_row(30, make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h8000, 16'h8000), 0, '0);
      add_row(30, make_sample(16'h7fff, 16'h1234, 16'hedcb, 16'h5555, 16'haaaa,
                              16'h0f0f, 16'hf0f0, 16'h3c3c, 16'hc3c3), 0, '0);
      add_row(1, make_sample(1, 1, -1, 1, -1, 1, -1, 1, -1), 0, '0);
      add_row(1, make_sample(3, -3, 3, 16'h7fff, 16'h8000, -9, 9, 2, -2), 0, '0);

      // Release reset on a falling clock edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].shift != active_shift)
            set_shift(directed_rows[i].shift);
         send_sample(directed_rows[i].sample, directed_rows[i].known,
                     directed_rows[i].want);
      end

      // Random phases: cycle through the idle patterns and a set of shifts with its extremes
      shift_plan[0] = 15;
      shift_plan[1] = 0;
      shift_plan[2] = 31;
      shift_plan[3] = 30;
      shift_plan[4] = 1;
      shift_plan[5] = 8;
      shift_plan[6] = 16;
      shift_plan[7] = $urandom_range(0, 31);
      for (int p = 0; p < 8; p++) begin
         set_shift(shift_plan[p]);
         mode = p % 4;
         // 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both
         sender_pct    = (mode == 1) ? 46 : (mode == 3) ? 19 : 0;
         receiver_pct <= (mode == 2) ? 46 : (mode == 3) ? 19 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off mid-phase until the pipeline is empty
            if (p == 3 && n == PHASE_ITEMS / 2)
               wait_drained();
            send_sample(random_sample(shift_plan[p]), 0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("[farrow_horner_interpolator_core] OK");
      else
         $display("[farrow_horner_interpolator_core] ERROR");
      $finish;
   end

endmodule
